// ===== hdl/lqct_pkg.sv =====
// ----------------------------------------------------------------------------
// lqct_pkg
// Shared types and constants of the link quality cost tracker.
// ----------------------------------------------------------------------------
`default_nettype none
package lqct_pkg;

	localparam int CntW   = 16;
	localparam int SumW   = 32;
	localparam int NumW   = 39;                  // sum_failed * 100
	localparam int DivCntW = 6;

	localparam logic [15:0] CostMax       = 16'hFFFF;
	localparam logic [6:0]  PctFull       = 7'd100;
	localparam logic [4:0]  CostGapPct    = 5'd31;   // ratio above 30 percent
	localparam logic [7:0]  LevelGapMin   = 8'd54;   // 100 * gap / 255 above 20
	localparam logic [31:0] ReliableSent  = 32'd10;

	localparam logic [15:0] RstPerThreshold  = 16'd100;
	localparam logic [15:0] RstMaxReports    = 16'd10;
	localparam logic [7:0]  RstPerWeight     = 8'd1;
	localparam logic [7:0]  RstCqiWeight     = 8'd1;
	localparam logic [7:0]  RstLevel         = 8'd125;
	localparam logic [15:0] RstCost          = 16'd100;

	typedef enum logic [1:0] {
		REG_PER_THRESHOLD = 2'd0,
		REG_MAX_REPORTS   = 2'd1,
		REG_PER_WEIGHT    = 2'd2,
		REG_CQI_WEIGHT    = 2'd3
	} reg_idx_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_UPD,
		ST_NUM,
		ST_DIV,
		ST_PROD,
		ST_FIN
	} state_t;

	typedef struct packed {
		logic capture;
		logic update;
		logic div_start;
		logic prod;
		logic finish;
	} cmd_t;

	typedef struct packed {
		logic div_done;
	} status_t;

endpackage
`default_nettype wire

// ===== hdl/lqct_if.sv =====
// ----------------------------------------------------------------------------
// lqct channel interfaces
// Report input channel and result output channel, valid/ready handshake.
// ----------------------------------------------------------------------------
`default_nettype none
interface lqct_in_if;
	logic        valid;
	logic        ready;
	logic        func;
	logic [7:0]  signal_level;
	logic [15:0] sent_count;
	logic [15:0] received_count;
	logic [15:0] failed_count;

	modport source (output valid, func, signal_level, sent_count, received_count,
		failed_count, input ready);
	modport sink (input valid, func, signal_level, sent_count, received_count,
		failed_count, output ready);
endinterface

interface lqct_out_if;
	logic        valid;
	logic        ready;
	logic        reevaluate;
	logic [15:0] fail_cost;
	logic [15:0] error_percent;
	logic [6:0]  quality_percent;
	logic [15:0] avg_sent;
	logic [15:0] avg_received;
	logic [15:0] avg_failed;

	modport source (output valid, reevaluate, fail_cost, error_percent,
		quality_percent, avg_sent, avg_received, avg_failed, input ready);
	modport sink (input valid, reevaluate, fail_cost, error_percent,
		quality_percent, avg_sent, avg_received, avg_failed, output ready);
endinterface
`default_nettype wire

// ===== hdl/link_quality_cost_tracker.sv =====
// ----------------------------------------------------------------------------
// link_quality_cost_tracker
// Link diagnostic report tracker: error and quality percent, weighted cost,
// re-evaluate flag.
// ----------------------------------------------------------------------------
// channel   dir  handshake          payload
// in_ch     in   valid/ready        func, signal_level, sent/received/failed
// out_ch    out  valid/ready        reevaluate, fail_cost, percents, averages
// cfg       in   cfg_we (no ready)  cfg_index, cfg_wdata
//
// one report runs from accept to result through the 39-step bit-serial
// error divider; the tracker then returns to idle to accept the next report
// a finished result sits in the output register, so a new report is taken
// while it waits; a report only stalls at its last step if it is still held
// reset clears all tracker state at once, no clearing pass
`default_nettype none
module link_quality_cost_tracker (
	input  wire logic        clk,
	input  wire logic        arst_n,
	lqct_in_if.sink          in_ch,
	lqct_out_if.source       out_ch,
	input  wire logic        cfg_we,
	input  wire logic [1:0]  cfg_index,
	input  wire logic [15:0] cfg_wdata
);
	import lqct_pkg::*;

	cmd_t    cmd;
	status_t status;

	// sequencer: one report at a time, output valid flag
	lqct_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_ch.valid),
		.in_ready  (in_ch.ready),
		.out_valid (out_ch.valid),
		.out_ready (out_ch.ready),
		.status    (status),
		.cmd       (cmd)
	);

	// state, config registers, divider, cost and change test
	lqct_dp u_dp (
		.clk               (clk),
		.arst_n            (arst_n),
		.cmd               (cmd),
		.status            (status),
		.cfg_we            (cfg_we),
		.cfg_index         (cfg_index),
		.cfg_wdata         (cfg_wdata),
		.in_func           (in_ch.func),
		.in_level          (in_ch.signal_level),
		.in_sent           (in_ch.sent_count),
		.in_received       (in_ch.received_count),
		.in_failed         (in_ch.failed_count),
		.o_reevaluate      (out_ch.reevaluate),
		.o_fail_cost       (out_ch.fail_cost),
		.o_error_percent   (out_ch.error_percent),
		.o_quality_percent (out_ch.quality_percent),
		.o_avg_sent        (out_ch.avg_sent),
		.o_avg_received    (out_ch.avg_received),
		.o_avg_failed      (out_ch.avg_failed)
	);
endmodule
`default_nettype wire

// ===== hdl/lqct_div.sv =====
// ----------------------------------------------------------------------------
// lqct_div
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none
module lqct_div (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic                     start,
	input  wire logic [lqct_pkg::NumW-1:0] dividend,
	input  wire logic [lqct_pkg::SumW-1:0] divisor,
	output logic                          done,
	output logic [lqct_pkg::NumW-1:0]     quotient
);
	import lqct_pkg::*;

	logic                busy_q;
	logic                done_q;
	logic [DivCntW-1:0]  cnt_q;
	logic [NumW-1:0]     quo_q;
	logic [SumW-1:0]     rem_q;
	logic [SumW-1:0]     div_q;
	logic [SumW:0]       trial;
	logic                fits;

	always_comb begin
		trial = {rem_q, quo_q[NumW-1]};
		fits  = trial >= {1'b0, div_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= DivCntW'(NumW);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == DivCntW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			div_q <= divisor;
		end else if (busy_q) begin
			quo_q <= {quo_q[NumW-2:0], fits};
			rem_q <= fits ? SumW'(trial - {1'b0, div_q}) : trial[SumW-1:0];
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;
endmodule
`default_nettype wire

// ===== hdl/lqct_dp.sv =====
// ----------------------------------------------------------------------------
// lqct_dp
// Datapath: tracker state, config registers, error divider, cost and decision.
// ----------------------------------------------------------------------------
`default_nettype none
module lqct_dp (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire lqct_pkg::cmd_t    cmd,
	output lqct_pkg::status_t      status,
	input  wire logic              cfg_we,
	input  wire logic [1:0]        cfg_index,
	input  wire logic [15:0]       cfg_wdata,
	input  wire logic              in_func,
	input  wire logic [7:0]        in_level,
	input  wire logic [15:0]       in_sent,
	input  wire logic [15:0]       in_received,
	input  wire logic [15:0]       in_failed,
	output logic                   o_reevaluate,
	output logic [15:0]            o_fail_cost,
	output logic [15:0]            o_error_percent,
	output logic [6:0]             o_quality_percent,
	output logic [15:0]            o_avg_sent,
	output logic [15:0]            o_avg_received,
	output logic [15:0]            o_avg_failed
);
	import lqct_pkg::*;

	logic [15:0] per_threshold_q, max_reports_q;
	logic [7:0]  per_weight_q, cqi_weight_q;

	logic        func_q;
	logic [15:0] sent_q, received_q, failed_q;
	logic [7:0]  level_now_q, level_ref_q;
	logic [15:0] cost_ref_q;
	logic [15:0] mean_sent_q, mean_received_q, mean_failed_q;
	logic [31:0] sum_sent_q, sum_received_q, sum_failed_q;
	logic [15:0] prev_sent_q, prev_received_q, prev_failed_q;
	logic [15:0] quiet_q;

	logic        err_ok_q;
	logic [6:0]  quality_q;
	logic [23:0] prod_err_q;
	logic [14:0] prod_cqi_q;
	logic [15:0] err_sat_q;
	logic        over_q;

	logic [NumW-1:0] numer, quotient;
	logic        div_done;
	logic [16:0] mean_s_sum, mean_r_sum, mean_f_sum;
	logic [14:0] level_x100;
	logic [8:0]  q_rem;
	logic [6:0]  quality;
	logic [15:0] err_sat;
	logic        over;
	logic [24:0] cost_sum;
	logic [15:0] cost;
	logic [15:0] ref_eff, cost_gap;
	logic [22:0] gap_x100, ref_x31;
	logic [7:0]  level_gap;
	logic        change;
	logic [16:0] quiet_next;

	// config writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			per_threshold_q <= RstPerThreshold;
			max_reports_q   <= RstMaxReports;
			per_weight_q    <= RstPerWeight;
			cqi_weight_q    <= RstCqiWeight;
		end else if (cfg_we) begin
			case (reg_idx_t'(cfg_index))
				REG_PER_THRESHOLD: per_threshold_q <= cfg_wdata;
				REG_MAX_REPORTS:   max_reports_q   <= cfg_wdata;
				REG_PER_WEIGHT:    per_weight_q    <= cfg_wdata[7:0];
				REG_CQI_WEIGHT:    cqi_weight_q    <= cfg_wdata[7:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		mean_s_sum = {1'b0, mean_sent_q} + {1'b0, sent_q};
		mean_r_sum = {1'b0, mean_received_q} + {1'b0, received_q};
		mean_f_sum = {1'b0, mean_failed_q} + {1'b0, failed_q};
		numer      = (NumW'(sum_failed_q) << 6) + (NumW'(sum_failed_q) << 5)
			+ (NumW'(sum_failed_q) << 2);
		// level * 100 / 255 with a single correction step
		level_x100 = 15'(level_now_q) * 15'd100;
		q_rem      = {1'b0, level_x100[7:0]} + {2'b0, level_x100[14:8]};
		quality    = level_x100[14:8] + 7'(q_rem >= 9'd255);
		err_sat    = (quotient[NumW-1:16] != '0) ? CostMax : quotient[15:0];
		over       = (quotient[NumW-1:16] != '0) || (quotient[15:0] > per_threshold_q);
		cost_sum   = 25'(prod_err_q) + 25'(prod_cqi_q);
		if (func_q && over_q)
			cost = CostMax;
		else
			cost = (cost_sum[24:16] != '0) ? CostMax : cost_sum[15:0];
		// gap is taken against the stored reference, a zero reference divides as one
		ref_eff    = (cost_ref_q == '0) ? 16'd1 : cost_ref_q;
		cost_gap   = (cost > cost_ref_q) ? cost - cost_ref_q : cost_ref_q - cost;
		gap_x100   = 23'(cost_gap) * 23'(PctFull);
		ref_x31    = 23'(ref_eff) * 23'(CostGapPct);
		level_gap  = (level_ref_q > level_now_q) ? level_ref_q - level_now_q
			: level_now_q - level_ref_q;
		change     = func_q ? (gap_x100 >= ref_x31) : (level_gap >= LevelGapMin);
		quiet_next = {1'b0, quiet_q} + 17'd1;
	end

	lqct_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div_start),
		.dividend (numer),
		.divisor  (sum_sent_q),
		.done     (div_done),
		.quotient (quotient)
	);

	assign status.div_done = div_done;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			level_now_q     <= RstLevel;
			level_ref_q     <= RstLevel;
			cost_ref_q      <= RstCost;
			mean_sent_q     <= 16'd1;
			mean_received_q <= '0;
			mean_failed_q   <= '0;
			sum_sent_q      <= '0;
			sum_received_q  <= '0;
			sum_failed_q    <= '0;
			prev_sent_q     <= '0;
			prev_received_q <= '0;
			prev_failed_q   <= '0;
			quiet_q         <= '0;
		end else begin
			if (cmd.capture)
				level_now_q <= in_level;
			if (cmd.update && func_q) begin
				sum_sent_q      <= sum_sent_q + 32'(16'(sent_q - prev_sent_q));
				sum_received_q  <= sum_received_q + 32'(16'(received_q - prev_received_q));
				sum_failed_q    <= sum_failed_q + 32'(16'(failed_q - prev_failed_q));
				prev_sent_q     <= sent_q;
				prev_received_q <= received_q;
				prev_failed_q   <= failed_q;
				mean_sent_q     <= (mean_s_sum[16:1] == '0) ? 16'd1 : mean_s_sum[16:1];
				mean_received_q <= mean_r_sum[16:1];
				mean_failed_q   <= mean_f_sum[16:1];
			end
			if (cmd.finish) begin
				if (change) begin
					quiet_q <= '0;
					if (func_q)
						cost_ref_q <= cost;
					else
						level_ref_q <= level_now_q;
				end else begin
					if (func_q)
						cost_ref_q <= ref_eff;
					if (quiet_next > {1'b0, max_reports_q})
						quiet_q <= '0;
					else
						quiet_q <= quiet_next[15:0];
				end
			end
		end
	end

	// item and intermediate registers
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			func_q     <= in_func;
			sent_q     <= in_sent;
			received_q <= in_received;
			failed_q   <= in_failed;
		end
		if (cmd.div_start) begin
			err_ok_q  <= func_q ? (sum_sent_q > ReliableSent) : (sum_sent_q != '0);
			quality_q <= quality;
		end
		if (cmd.prod) begin
			err_sat_q  <= err_ok_q ? err_sat : '0;
			over_q     <= err_ok_q && over;
			prod_err_q <= 24'(per_weight_q) * 24'(err_ok_q ? err_sat : 16'd0);
			prod_cqi_q <= 15'(cqi_weight_q) * 15'(PctFull - quality_q);
		end
		if (cmd.finish) begin
			o_reevaluate      <= change || (quiet_next > {1'b0, max_reports_q});
			o_fail_cost       <= cost;
			o_error_percent   <= err_sat_q;
			o_quality_percent <= quality_q;
			o_avg_sent        <= mean_sent_q;
			o_avg_received    <= mean_received_q;
			o_avg_failed      <= mean_failed_q;
		end
	end
endmodule
`default_nettype wire

// ===== hdl/lqct_ctrl.sv =====
// ----------------------------------------------------------------------------
// lqct_ctrl
// Sequencer for one report and the output valid flag.
// ----------------------------------------------------------------------------
`default_nettype none
module lqct_ctrl (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	output logic                   in_ready,
	output logic                   out_valid,
	input  wire logic              out_ready,
	input  wire lqct_pkg::status_t status,
	output lqct_pkg::cmd_t         cmd
);
	import lqct_pkg::*;

	state_t state_q, state_d;
	logic   out_valid_q;
	logic   out_free;

	assign out_free = !out_valid_q || out_ready;

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: if (in_valid) state_d = ST_UPD;
			ST_UPD:  state_d = ST_NUM;
			ST_NUM:  state_d = ST_DIV;
			ST_DIV:  if (status.div_done) state_d = ST_PROD;
			ST_PROD: state_d = ST_FIN;
			ST_FIN:  if (out_free) state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		in_ready      = 1'b0;
		cmd           = '0;
		case (state_q)
			ST_IDLE: begin
				in_ready    = 1'b1;
				cmd.capture = in_valid;
			end
			ST_UPD:  cmd.update = 1'b1;
			ST_NUM:  cmd.div_start = 1'b1;
			ST_DIV:  ;
			ST_PROD: cmd.prod = 1'b1;
			ST_FIN:  cmd.finish = out_free;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.finish)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
		end
	end

	assign out_valid = out_valid_q;

`ifndef SYNTHESIS
	a_accept_starts: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> state_q == ST_UPD) else $error("accept did not start");
	a_finish_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.finish |-> (!out_valid_q || out_ready)) else $error("result overwritten");
	a_div_to_prod: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_DIV && status.div_done |=> state_q == ST_PROD)
		else $error("divider done missed");
	a_valid_from_fin: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q) == ST_FIN) else $error("stray result");
`endif
endmodule
`default_nettype wire
